### src/mua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mua_pkg: shared constants and types for the meter usage accumulator
// Opcodes, status codes, geometry of the total stores and read item codes.
// ----------------------------------------------------------------------------
package mua_pkg;

  localparam int unsigned Points        = 8;
  localparam int unsigned TariffPeriods = 4;
  localparam int unsigned Channels      = 4;
  localparam int unsigned Slots         = TariffPeriods + 1;
  localparam int unsigned Entries       = Points * Channels * Slots;
  localparam int unsigned AddrW         = $clog2(Entries);

  typedef logic [AddrW-1:0] addr_t;

  localparam logic [1:0] OpUpdate   = 2'd0;
  localparam logic [1:0] OpClrDay   = 2'd1;
  localparam logic [1:0] OpClrMonth = 2'd2;
  localparam logic [1:0] OpRead     = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoItm = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  localparam logic [15:0] ItemDayCh0 = 16'h0501;
  localparam logic [15:0] ItemDayCh1 = 16'h0502;
  localparam logic [15:0] ItemDayCh2 = 16'h0504;
  localparam logic [15:0] ItemDayCh3 = 16'h0508;
  localparam logic [15:0] ItemMonCh0 = 16'h0510;
  localparam logic [15:0] ItemMonCh1 = 16'h0520;
  localparam logic [15:0] ItemMonCh2 = 16'h0540;
  localparam logic [15:0] ItemMonCh3 = 16'h0580;

  localparam logic [31:0] NoReading = 32'hffff_ffff;

  // one BCD byte to binary 0..165
  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    bcd_byte = 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

endpackage

### src/mua_bcd_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mua_bcd_conv: sequential binary to 8-digit BCD converter
// Takes the value modulo 10^8 by repeated conditional subtraction of
// scaled powers, then double-dabble, one bit per cycle.
// ----------------------------------------------------------------------------
module mua_bcd_conv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] bcd_o
);

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_DAB, S_DONE} state_e;

  state_e      state_q;
  logic [31:0] val_q;
  logic [31:0] bcd_q;
  logic [5:0]  cnt_q;
  logic [31:0] sub_q;
  logic [31:0] adj;

  // add 3 to each digit at or above five
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            val_q   <= value_i;
            sub_q   <= 32'd3_200_000_000;
            cnt_q   <= 6'd5;
            state_q <= S_MOD;
          end
        end
        // subtract 32e8, 16e8 .. 1e8 in turn: reduces below 1e8
        S_MOD: begin
          if (val_q >= sub_q) val_q <= val_q - sub_q;
          sub_q <= sub_q >> 1;
          if (cnt_q == 6'd0) begin
            cnt_q   <= 6'd32;
            bcd_q   <= '0;
            state_q <= S_DAB;
          end else begin
            cnt_q <= cnt_q - 6'd1;
          end
        end
        S_DAB: begin
          bcd_q <= {adj[30:0], val_q[31]};
          val_q <= val_q << 1;
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= S_DONE;
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = (state_q == S_DONE);
  assign bcd_o  = bcd_q;

endmodule

### src/meter_usage_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// meter_usage_accumulator_top: energy usage accumulator, four channels
// of five tariff slots per point; totals kept in on-chip memories.
// ----------------------------------------------------------------------------
// After accept, an update result follows a memory read with reading scaling,
// the delta and the write back. A clear walks all 160 entries.
// A read emits five words, each made after accept or after the word before
// it is taken by a memory read, scaling and BCD conversion.
// One word at a time: the next word is taken once the result is taken.
// Reset: a clearing pass of the memories, then words are taken.
module meter_usage_accumulator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  point_i,
  input  logic [1:0]  channel_i,
  input  logic [2:0]  tariff_i,
  input  logic [31:0] reading_low_bcd_i,
  input  logic [7:0]  reading_high_bcd_i,
  input  logic [15:0] item_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] usage_delta_o,
  output logic [2:0]  slot_index_o,
  output logic [2:0]  slot_count_o,
  output logic [31:0] total_bcd_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_UPD_RD, S_UPD_CALC, S_UPD_WR, S_CLR, S_RD_MEM,
    S_RD_MUL, S_RD_CONV, S_RD_WAIT, S_OUT
  } state_e;

  localparam int unsigned Ew = mua_pkg::AddrW;

  // configuration register
  logic [7:0] empty_q;
  assign pready = 1'b1;
  assign prdata = {24'd0, empty_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) empty_q <= 8'hff;
    else if (psel && penable && pwrite && paddr == 2'd0) empty_q <= pwdata[7:0];
  end

  // memories
  logic [31:0] prev_mem [mua_pkg::Entries];
  logic [31:0] day_mem  [mua_pkg::Entries];
  logic [31:0] mon_mem  [mua_pkg::Entries];
  logic [31:0] prev_rd_q, day_rd_q, mon_rd_q;
  logic        we_prev, we_day, we_mon;
  mua_pkg::addr_t waddr, raddr;
  logic [31:0] wprev, wday, wmon;

  always_ff @(posedge clk_i) begin
    if (we_prev) prev_mem[waddr] <= wprev;
    if (we_day)  day_mem[waddr]  <= wday;
    if (we_mon)  mon_mem[waddr]  <= wmon;
    prev_rd_q <= prev_mem[raddr];
    day_rd_q  <= day_mem[raddr];
    mon_rd_q  <= mon_mem[raddr];
  end

  state_e       state_q;
  logic [1:0]   op_q;
  logic [Ew-1:0] base_q;
  logic [Ew-1:0] cnt_q;
  logic [2:0]   slot_q;
  logic         active_q, month_q;
  logic [31:0]  cur_q, delta_q, prod_q;
  logic [7:0]   hib_q;
  logic [1:0]   st_q;
  logic [31:0]  dlt_o_q, bcd_o_q;
  logic [2:0]   si_q, sc_q;
  logic         last_q, ovalid_q;
  logic         conv_start;
  logic         conv_done;
  logic [31:0]  conv_bcd;

  mua_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (prod_q),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  // input decode
  logic        in_act, in_empty, in_badpt, in_badtf;
  logic [31:0] low_bin, lowdiv;
  logic        item_ok, item_mon;
  logic [1:0]  item_ch;
  logic [Ew-1:0] in_idx;

  always_comb begin
    in_act   = (channel_i == 2'd0) || (channel_i == 2'd2);
    in_empty = (reading_low_bcd_i == {4{empty_q}}) &&
               (!in_act || reading_high_bcd_i == empty_q);
    in_badpt = ({1'b0, point_i} >= 4'(mua_pkg::Points));
    in_badtf = (tariff_i > 3'(mua_pkg::TariffPeriods));
    low_bin  = 32'(mua_pkg::bcd_byte(reading_low_bcd_i[31:24])) * 32'd1000000
             + 32'(mua_pkg::bcd_byte(reading_low_bcd_i[23:16])) * 32'd10000
             + 32'(mua_pkg::bcd_byte(reading_low_bcd_i[15:8]))  * 32'd100
             + 32'(mua_pkg::bcd_byte(reading_low_bcd_i[7:0]));
    item_ok  = 1'b1;
    item_ch  = 2'd0;
    item_mon = 1'b0;
    unique case (item_code_i)
      mua_pkg::ItemDayCh0: begin item_ch = 2'd0; item_mon = 1'b0; end
      mua_pkg::ItemDayCh1: begin item_ch = 2'd1; item_mon = 1'b0; end
      mua_pkg::ItemDayCh2: begin item_ch = 2'd2; item_mon = 1'b0; end
      mua_pkg::ItemDayCh3: begin item_ch = 2'd3; item_mon = 1'b0; end
      mua_pkg::ItemMonCh0: begin item_ch = 2'd0; item_mon = 1'b1; end
      mua_pkg::ItemMonCh1: begin item_ch = 2'd1; item_mon = 1'b1; end
      mua_pkg::ItemMonCh2: begin item_ch = 2'd2; item_mon = 1'b1; end
      mua_pkg::ItemMonCh3: begin item_ch = 2'd3; item_mon = 1'b1; end
      default:             item_ok = 1'b0;
    endcase
    in_idx = Ew'((({5'd0, point_i} * 8'd4) + {6'd0,
             (opcode_i == mua_pkg::OpRead) ? item_ch : channel_i}) * 8'd5);
  end

  // low eight digits divided by ten, from the registered binary value
  assign lowdiv = 32'((64'(cur_q) * 64'hCCCC_CCCD) >> 35);

  assign in_ready_o = (state_q == S_IDLE) && !ovalid_q;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // memory port control
  always_comb begin
    we_prev = 1'b0;
    we_day  = 1'b0;
    we_mon  = 1'b0;
    waddr   = cnt_q;
    wprev   = mua_pkg::NoReading;
    wday    = '0;
    wmon    = '0;
    raddr   = base_q + Ew'(slot_q);
    conv_start = 1'b0;
    unique case (state_q)
      S_INIT: begin
        we_prev = 1'b1; we_day = 1'b1; we_mon = 1'b1;
      end
      S_CLR: begin
        we_day = (op_q == mua_pkg::OpClrDay);
        we_mon = (op_q == mua_pkg::OpClrMonth);
      end
      S_UPD_WR: begin
        waddr = base_q;
        we_prev = 1'b1; we_day = 1'b1; we_mon = 1'b1;
        wprev = cur_q;
        wday  = day_rd_q + delta_q;
        wmon  = mon_rd_q + delta_q;
      end
      S_RD_CONV: conv_start = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + Ew'(1);
          if (cnt_q == Ew'(mua_pkg::Entries - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) begin
            op_q     <= opcode_i;
            base_q   <= in_idx;
            active_q <= (opcode_i == mua_pkg::OpRead) ?
                        ((item_ch == 2'd0) || (item_ch == 2'd2)) : in_act;
            month_q  <= item_mon;
            cur_q    <= low_bin;
            hib_q    <= mua_pkg::bcd_byte(reading_high_bcd_i);
            dlt_o_q  <= '0; si_q <= '0; sc_q <= '0; bcd_o_q <= '0;
            last_q   <= 1'b1;
            st_q     <= mua_pkg::StOk;
            cnt_q    <= '0;
            slot_q   <= '0;
            unique case (opcode_i)
              mua_pkg::OpUpdate: begin
                if (in_badpt || in_badtf) begin
                  st_q <= mua_pkg::StNoItm; ovalid_q <= 1'b1;
                end else if (in_empty) begin
                  st_q <= mua_pkg::StEmpty; ovalid_q <= 1'b1;
                end else begin
                  base_q  <= in_idx + Ew'(tariff_i);
                  state_q <= S_UPD_RD;
                end
              end
              mua_pkg::OpClrDay, mua_pkg::OpClrMonth: state_q <= S_CLR;
              default: begin
                if (!item_ok || in_badpt) begin
                  st_q <= mua_pkg::StNoItm; ovalid_q <= 1'b1;
                end else begin
                  state_q <= S_RD_MEM;
                end
              end
            endcase
          end
        end
        // active readings: high byte times 10^7 plus low digits over ten
        S_UPD_RD: begin
          slot_q  <= '0;
          if (active_q) cur_q <= 32'(hib_q) * 32'd10000000 + lowdiv;
          state_q <= S_UPD_CALC;
        end
        S_UPD_CALC: begin
          if (prev_rd_q == mua_pkg::NoReading || cur_q < prev_rd_q) delta_q <= '0;
          else delta_q <= cur_q - prev_rd_q;
          state_q <= S_UPD_WR;
        end
        S_UPD_WR: begin
          dlt_o_q  <= delta_q;
          ovalid_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_CLR: begin
          cnt_q <= cnt_q + Ew'(1);
          if (cnt_q == Ew'(mua_pkg::Entries - 1)) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        S_RD_MEM: state_q <= S_RD_MUL;
        S_RD_MUL: begin
          prod_q  <= (month_q ? mon_rd_q : day_rd_q) * (active_q ? 32'd10 : 32'd100);
          state_q <= S_RD_CONV;
        end
        S_RD_CONV: state_q <= S_RD_WAIT;
        S_RD_WAIT: begin
          if (conv_done) begin
            bcd_o_q  <= conv_bcd;
            si_q     <= slot_q;
            sc_q     <= 3'(mua_pkg::TariffPeriods);
            last_q   <= (slot_q == 3'(mua_pkg::Slots - 1));
            ovalid_q <= 1'b1;
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_q || out_ready_i) begin
            if (slot_q == 3'(mua_pkg::Slots - 1)) begin
              state_q <= S_IDLE;
            end else begin
              slot_q  <= slot_q + 3'd1;
              state_q <= S_RD_MEM;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = ovalid_q;
  assign status_o      = st_q;
  assign usage_delta_o = dlt_o_q;
  assign slot_index_o  = si_q;
  assign slot_count_o  = sc_q;
  assign total_bcd_o   = bcd_o_q;
  assign last_o        = last_q;

endmodule

### src/mua_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mua_checker: port-level checks for the meter usage accumulator
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module mua_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] usage_delta_o,
  input logic [2:0]  slot_count_o,
  input logic        last_o
);

  // a held word keeps its flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(last_o))
    else $error("held word changed");

  // no new word while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("accept with pending result");

  // error words are single and carry no delta
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 2'd0 |-> last_o && usage_delta_o == 32'd0)
    else $error("bad error word");

  // read words carry the period count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_count_o != 3'd0 |-> slot_count_o == 3'd4)
    else $error("bad slot count");

endmodule

bind meter_usage_accumulator_top mua_checker u_mua_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .usage_delta_o (usage_delta_o),
  .slot_count_o  (slot_count_o),
  .last_o        (last_o)
);
